[design/ptpm_pkg.sv]
// ----------------------------------------------------------------------------
// Packed trie prefix matcher package
// Shared sizes and the structs that pass between the search engine and the
// top level.
// ----------------------------------------------------------------------------
package ptpm_pkg;

  // Table size and derived address widths
  localparam int TABLE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(TABLE_BYTES);
  // Wide enough for a node address plus count, padding and child offset
  localparam int IA_W        = ((ADDR_W > 11) ? ADDR_W : 11) + 2;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 13;
  localparam int LEN_W       = 16;
  localparam int CHILD_W     = 32;
  localparam int MAX_LENGTH  = 65535;

  // Table memory request from the search engine
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ptpm_mem_req_t;

  // Finished result offered to the output register
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] length;
    logic             fault;
  } ptpm_result_t;

endpackage

[design/packed_trie_prefix_matcher.sv]
// ----------------------------------------------------------------------------
// Packed trie prefix matcher
// Longest keyword match at the start of a text, over a trie packed into a
// byte table.
// ----------------------------------------------------------------------------
// A table-write transaction (kind 0) is written in the idle state. A text
// character (kind 1) goes straight to the finish state once the search has
// ended, on an empty table or when the node address lies outside the table;
// else the count byte is read, which ends the search if the node does not fit
// or has no keys. Otherwise K keys are scanned (1 to 255): a miss or a child
// index slot outside the table ends the search, else the child index is read,
// then the key after the match when it must be checked for a repeat. The table
// memory has a single read port: the count byte, each key and each of the four
// child index bytes are read one per cycle. On the final character one result
// transaction is offered; the output register lets the next text start while
// it waits, and a further result waits in the sequencer while that register is
// stalled. The table memory has no reset; only written bytes may be read.
// ----------------------------------------------------------------------------
module packed_trie_prefix_matcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [ptpm_pkg::CFG_W-1:0]  cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [ptpm_pkg::ADDR_W-1:0] table_address,
  input  logic [ptpm_pkg::BYTE_W-1:0] table_byte,
  input  logic [ptpm_pkg::BYTE_W-1:0] text_char,
  input  logic                        last_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ptpm_pkg::LEN_W-1:0]  match_length,
  output logic                        table_fault
);
  import ptpm_pkg::*;

  logic [CFG_W-1:0]  table_length;
  logic [IA_W-1:0]   lim;
  ptpm_mem_req_t     mem_req;
  logic [BYTE_W-1:0] rd_data;
  ptpm_result_t      res;
  logic              res_ready;

  // Hold the table length register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
    end else if (cfg_write_enable) begin
      table_length <= cfg_write_data;
    end
  end

  // Clamp the valid length to the table size
  assign lim = (IA_W'(table_length) > IA_W'(TABLE_BYTES)) ? IA_W'(TABLE_BYTES)
                                                          : IA_W'(table_length);

  ptpm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  ptpm_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .table_address (table_address),
    .table_byte    (table_byte),
    .text_char     (text_char),
    .last_char     (last_char),
    .lim           (lim),
    .mem_req       (mem_req),
    .rd_data       (rd_data),
    .res           (res),
    .res_ready     (res_ready)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
    if (res_ready && res.valid) begin
      match_length <= res.length;
      table_fault  <= res.fault;
    end
  end

  // The memory is never written while a search read is in flight
  assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> !mem_req.rd_en)
    else $error("table write collides with a search read");

  // A result that cannot be taken is held by the sequencer
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_ready) |=> (res.valid && $stable(res.length)
                                   && $stable(res.fault)))
    else $error("pending result dropped or changed");

  // The output register only fills from an offered result
  assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |=> (out_valid == $past(res.valid)))
    else $error("output register loaded without a result");

  // Writes are only taken while the sequencer is idle
  assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (in_valid && !in_stall && !kind))
    else $error("table write outside a write transaction");

endmodule

[design/ptpm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/ptpm_seq.sv]
// ----------------------------------------------------------------------------
// Trie search sequencer
// Takes input transactions, writes table bytes, and walks one trie node per
// text character through single-byte reads of the table memory.
// ----------------------------------------------------------------------------
module ptpm_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [ptpm_pkg::ADDR_W-1:0]   table_address,
  input  logic [ptpm_pkg::BYTE_W-1:0]   table_byte,
  input  logic [ptpm_pkg::BYTE_W-1:0]   text_char,
  input  logic                          last_char,
  input  logic [ptpm_pkg::IA_W-1:0]     lim,
  output ptpm_pkg::ptpm_mem_req_t       mem_req,
  input  logic [ptpm_pkg::BYTE_W-1:0]   rd_data,
  output ptpm_pkg::ptpm_result_t        res,
  input  logic                          res_ready
);
  import ptpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_KEY,
    S_INDEX,
    S_DUP,
    S_FINISH
  } state_t;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   node, node_next;
  logic [LEN_W-1:0]    chars, chars_next;
  logic [LEN_W-1:0]    best, best_next;
  logic                done, done_next;
  logic                fault, fault_next;
  logic [BYTE_W-1:0]   ch, ch_next;
  logic                last, last_next;
  logic [BYTE_W-1:0]   num, num_next;
  logic [BYTE_W-1:0]   kidx, kidx_next;
  logic [ADDR_W-1:0]   ia, ia_next;
  logic [1:0]          bsel, bsel_next;
  logic [CHILD_W-1:0]  child, child_next;

  logic [IA_W-1:0]     node_ext;
  logic [IA_W-1:0]     ia_full;
  logic [IA_W-1:0]     key_next_addr;
  logic [CHILD_W-1:0]  child_now;
  logic                more_keys;
  logic                do_resolve;
  logic                dup_hit;

  assign in_stall = (state != S_IDLE);
  assign node_ext = IA_W'(node);

  // Child index slot address: align past the keys, then step by slot
  assign ia_full = ((node_ext + IA_W'(num) + IA_W'(4)) & ~IA_W'(3))
                 + IA_W'({kidx, 2'b00});
  // Address of the key after the current one
  assign key_next_addr = node_ext + IA_W'(2) + IA_W'(kidx);
  assign more_keys = ({1'b0, kidx} + 9'd1) < {1'b0, num};
  // Child index as it stands once the last byte is in
  assign child_now = (state == S_INDEX) ? {rd_data, child[CHILD_W-1:BYTE_W]} : child;

  always_comb begin
    state_next = state;
    node_next  = node;
    chars_next = chars;
    best_next  = best;
    done_next  = done;
    fault_next = fault;
    ch_next    = ch;
    last_next  = last;
    num_next   = num;
    kidx_next  = kidx;
    ia_next    = ia;
    bsel_next  = bsel;
    child_next = child;
    mem_req    = '0;
    res        = '0;
    do_resolve = 1'b0;
    dup_hit    = 1'b0;

    unique case (state)
      // Take a transaction: write a byte, or start on a character
      S_IDLE: begin
        if (in_valid) begin
          if (!kind) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = table_address;
            mem_req.wr_data = table_byte;
          end else begin
            ch_next    = text_char;
            last_next  = last_char;
            state_next = S_FINISH;
            if (done) begin
              state_next = S_FINISH;
            end else if (lim == '0) begin
              done_next = 1'b1;
            end else begin
              if (chars < LEN_W'(MAX_LENGTH)) begin
                chars_next = chars + LEN_W'(1);
              end
              if (node_ext >= lim) begin
                fault_next = 1'b1;
                done_next  = 1'b1;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = node;
                state_next      = S_COUNT;
              end
            end
          end
        end
      end

      // Check the node fits, then fetch the first key
      S_COUNT: begin
        num_next  = rd_data;
        kidx_next = '0;
        if ((node_ext + IA_W'(rd_data)) >= lim) begin
          fault_next = 1'b1;
          done_next  = 1'b1;
          state_next = S_FINISH;
        end else if (rd_data == '0) begin
          done_next  = 1'b1;
          state_next = S_FINISH;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = node + ADDR_W'(1);
          state_next      = S_KEY;
        end
      end

      // Scan keys for the first one not below the character
      S_KEY: begin
        if ($signed(rd_data) >= $signed(ch)) begin
          if (rd_data == ch) begin
            if ((ia_full + IA_W'(3)) >= lim) begin
              fault_next = 1'b1;
              done_next  = 1'b1;
              state_next = S_FINISH;
            end else begin
              ia_next         = ia_full[ADDR_W-1:0];
              bsel_next       = '0;
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = ia_full[ADDR_W-1:0];
              state_next      = S_INDEX;
            end
          end else begin
            done_next  = 1'b1;
            state_next = S_FINISH;
          end
        end else if (!more_keys) begin
          done_next  = 1'b1;
          state_next = S_FINISH;
        end else begin
          kidx_next       = kidx + BYTE_W'(1);
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = key_next_addr[ADDR_W-1:0];
        end
      end

      // Gather the child index, low byte first
      S_INDEX: begin
        child_next = child_now;
        if (bsel == 2'd3) begin
          if (more_keys) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = key_next_addr[ADDR_W-1:0];
            state_next      = S_DUP;
          end else begin
            do_resolve = 1'b1;
          end
        end else begin
          bsel_next       = bsel + 2'd1;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ia + ADDR_W'(bsel) + ADDR_W'(1);
        end
      end

      // A repeated key marks a word end with children
      S_DUP: begin
        do_resolve = 1'b1;
        dup_hit    = (rd_data == ch);
      end

      // Hand over the result on the final character, then clear the text
      S_FINISH: begin
        if (!last) begin
          state_next = S_IDLE;
        end else begin
          res.valid  = 1'b1;
          res.length = best;
          res.fault  = fault;
          if (res_ready) begin
            node_next  = '0;
            chars_next = '0;
            best_next  = '0;
            done_next  = 1'b0;
            fault_next = 1'b0;
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Follow the child, or stop on a leaf or a bad index
    if (do_resolve) begin
      state_next = S_FINISH;
      if (dup_hit) begin
        best_next = chars;
      end
      if (child_now == '0) begin
        best_next = chars;
        done_next = 1'b1;
      end else if (child_now >= CHILD_W'(lim)) begin
        fault_next = 1'b1;
        done_next  = 1'b1;
      end else begin
        node_next = child_now[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node  <= '0;
      chars <= '0;
      best  <= '0;
      done  <= 1'b0;
      fault <= 1'b0;
    end else begin
      state <= state_next;
      node  <= node_next;
      chars <= chars_next;
      best  <= best_next;
      done  <= done_next;
      fault <= fault_next;
    end
    ch    <= ch_next;
    last  <= last_next;
    num   <= num_next;
    kidx  <= kidx_next;
    ia    <= ia_next;
    bsel  <= bsel_next;
    child <= child_next;
  end

endmodule
